[design/qafm_pkg.sv]
// Shared types, register codes and reset constants for the quad arming,
// failsafe and motor mixer block. No dependencies.
package qafm_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PW_W       = 12;
   localparam int TIMER_W    = 16;
   localparam int MIX_W      = 20;
   localparam int NUM_MOTORS = 4;

   typedef logic [PW_W-1:0]        pw_type;
   typedef logic [TIMER_W-1:0]     timer_type;
   typedef logic signed [MIX_W-1:0] mix_sum_type;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_VALUE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_FLOOR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_CEILING   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_HOLD_MS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TIMEOUT  = 3'd5;

   localparam logic [7:0] MAGIC_VALUE_RST   = 8'hA5;
   localparam pw_type     THR_FLOOR_RST     = 12'd1000;
   localparam pw_type     THR_CEILING_RST   = 12'd2000;
   localparam pw_type     LOW_THR_LIMIT_RST = 12'd1080;
   localparam timer_type  ARM_HOLD_MS_RST   = 16'd2000;
   localparam timer_type  LINK_TIMEOUT_RST  = 16'd500;
   localparam timer_type  SILENCE_RST       =
      (LINK_TIMEOUT_RST == 16'hFFFF) ? 16'hFFFF : LINK_TIMEOUT_RST + 16'd1;

   typedef struct packed {
      logic [7:0] magic_value;
      pw_type     throttle_floor;
      pw_type     throttle_ceiling;
      pw_type     low_throttle_limit;
      timer_type  arm_hold_ms;
      timer_type  link_timeout_ms;
   } cfg_type;

   typedef struct packed {
      pw_type [NUM_MOTORS-1:0] motor;
      pw_type                  idle;
      logic                    base_low;
   } mix_type;

   // Saturate x into [lo, hi]; a floor above the ceiling yields the floor for x below it, else the ceiling
   function automatic pw_type clamp_pw(mix_sum_type x, pw_type lo, pw_type hi);
      mix_sum_type lo_s;
      mix_sum_type hi_s;
      pw_type      res;
      lo_s = mix_sum_type'({{(MIX_W-PW_W){1'b0}}, lo});
      hi_s = mix_sum_type'({{(MIX_W-PW_W){1'b0}}, hi});
      if (x < lo_s) begin
         res = lo;
      end else if (x > hi_s) begin
         res = hi;
      end else begin
         res = x[PW_W-1:0];
      end
      return res;
   endfunction

   function automatic timer_type sat_inc(timer_type v);
      return (v == {TIMER_W{1'b1}}) ? v : v + timer_type'(1);
   endfunction

endpackage

[design/quad_arming_failsafe_mixer_unit.sv]
// Quadcopter X mixer with arming interlock and link failsafe.
// A word accepted on req passes from the input register into the result register and
// then appears on rsp. One word per cycle while rsp_ready does not stall the result register.
// Reset (synchronous): disarmed, hold cleared, silence timer at timeout plus one,
// motors at the floor reset value, config registers at their reset values.
// Depends on qafm_pkg, qafm_csr, qafm_mixer.
module quad_arming_failsafe_mixer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [7:0]                       req_tag,
   input  logic [15:0]                      req_throttle_in,
   input  logic signed [15:0]               req_pitch_in,
   input  logic signed [15:0]               req_roll_in,
   input  logic signed [15:0]               req_yaw_in,
   input  logic [7:0]                       req_arm_request,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [11:0]                      rsp_motor_front_left,
   output logic [11:0]                      rsp_motor_front_right,
   output logic [11:0]                      rsp_motor_rear_right,
   output logic [11:0]                      rsp_motor_rear_left,
   output logic                             rsp_armed_out,
   output logic                             rsp_packet_accepted,
   output logic                             rsp_failsafe_trip,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qafm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qafm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   qafm_pkg::cfg_type cfg;
   qafm_pkg::mix_type mix;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               mode_ff;
   logic [7:0]         tag_ff;
   logic [15:0]        thr_ff;
   logic signed [15:0] pitch_ff;
   logic signed [15:0] roll_ff;
   logic signed [15:0] yaw_ff;
   logic [7:0]         arm_req_ff;

   // block state and result register
   logic                                          rsp_valid_ff, rsp_valid_in;
   logic                                          armed_ff, armed_in;
   logic                                          hold_active_ff, hold_active_in;
   qafm_pkg::timer_type                           hold_elapsed_ff, hold_elapsed_in;
   qafm_pkg::timer_type                           silence_ff, silence_in;
   qafm_pkg::pw_type [qafm_pkg::NUM_MOTORS-1:0]   motor_ff, motor_in;
   logic                                          accepted_ff, accepted_in;
   logic                                          trip_ff, trip_in;

   logic                req_take;
   logic                advance;
   logic                do_idle;
   qafm_pkg::timer_type hold_eff;
   qafm_pkg::timer_type silence_next;

   qafm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qafm_mixer u_mixer (
      .cfg      (cfg),
      .throttle (thr_ff),
      .pitch    (pitch_ff),
      .roll     (roll_ff),
      .yaw      (yaw_ff),
      .mix      (mix)
   );

   // advance when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      armed_in        = armed_ff;
      hold_active_in  = hold_active_ff;
      hold_elapsed_in = hold_elapsed_ff;
      silence_in      = silence_ff;
      motor_in        = motor_ff;
      accepted_in     = accepted_ff;
      trip_in         = trip_ff;
      do_idle         = 1'b0;
      hold_eff        = hold_active_ff ? hold_elapsed_ff : '0;
      silence_next    = qafm_pkg::sat_inc(silence_ff);
      if (advance) begin
         accepted_in = 1'b0;
         trip_in     = 1'b0;
         if (!mode_ff) begin
            if (tag_ff == cfg.magic_value) begin
               accepted_in = 1'b1;
               silence_in  = '0;
               if (!armed_ff) begin
                  // restart the hold on its first qualifying packet
                  if ((arm_req_ff != 8'd0) &&
                      (thr_ff < {4'd0, cfg.low_throttle_limit})) begin
                     hold_active_in  = 1'b1;
                     hold_elapsed_in = hold_eff;
                     if (hold_eff >= cfg.arm_hold_ms) begin
                        armed_in = 1'b1;
                     end
                  end else begin
                     hold_active_in  = 1'b0;
                     hold_elapsed_in = '0;
                  end
                  do_idle = 1'b1;
               end else if (mix.base_low) begin
                  do_idle = 1'b1;
               end else begin
                  motor_in = mix.motor;
               end
            end
         end else begin
            if (hold_active_ff) begin
               hold_elapsed_in = qafm_pkg::sat_inc(hold_elapsed_ff);
            end
            silence_in = silence_next;
            if (silence_next > cfg.link_timeout_ms) begin
               trip_in         = 1'b1;
               armed_in        = 1'b0;
               hold_active_in  = 1'b0;
               hold_elapsed_in = '0;
               do_idle         = 1'b1;
            end
         end
         if (do_idle) begin
            motor_in = {qafm_pkg::NUM_MOTORS{mix.idle}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         armed_ff        <= 1'b0;
         hold_active_ff  <= 1'b0;
         hold_elapsed_ff <= '0;
         silence_ff      <= qafm_pkg::SILENCE_RST;
         motor_ff        <= {qafm_pkg::NUM_MOTORS{qafm_pkg::THR_FLOOR_RST}};
         accepted_ff     <= 1'b0;
         trip_ff         <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         armed_ff        <= armed_in;
         hold_active_ff  <= hold_active_in;
         hold_elapsed_ff <= hold_elapsed_in;
         silence_ff      <= silence_in;
         motor_ff        <= motor_in;
         accepted_ff     <= accepted_in;
         trip_ff         <= trip_in;
      end
   end

   // payload of the input register; hold while not taking a word
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff    <= req_mode;
         tag_ff     <= req_tag;
         thr_ff     <= req_throttle_in;
         pitch_ff   <= req_pitch_in;
         roll_ff    <= req_roll_in;
         yaw_ff     <= req_yaw_in;
         arm_req_ff <= req_arm_request;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_motor_front_left  = motor_ff[0];
   assign rsp_motor_front_right = motor_ff[1];
   assign rsp_motor_rear_right  = motor_ff[2];
   assign rsp_motor_rear_left   = motor_ff[3];
   assign rsp_armed_out         = armed_ff;
   assign rsp_packet_accepted   = accepted_ff;
   assign rsp_failsafe_trip     = trip_ff;

endmodule

[design/qafm_csr.sv]
// Configuration register file for the mixer block.
// Depends on qafm_pkg for register codes, reset values and cfg_type.
module qafm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qafm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qafm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output qafm_pkg::cfg_type                cfg
);

   qafm_pkg::cfg_type cfg_ff;
   qafm_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            qafm_pkg::CSR_MAGIC_VALUE:   cfg_in.magic_value        = csr_wdata[7:0];
            qafm_pkg::CSR_THR_FLOOR:     cfg_in.throttle_floor     = csr_wdata[11:0];
            qafm_pkg::CSR_THR_CEILING:   cfg_in.throttle_ceiling   = csr_wdata[11:0];
            qafm_pkg::CSR_LOW_THR_LIMIT: cfg_in.low_throttle_limit = csr_wdata[11:0];
            qafm_pkg::CSR_ARM_HOLD_MS:   cfg_in.arm_hold_ms        = csr_wdata;
            qafm_pkg::CSR_LINK_TIMEOUT:  cfg_in.link_timeout_ms    = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_value        <= qafm_pkg::MAGIC_VALUE_RST;
         cfg_ff.throttle_floor     <= qafm_pkg::THR_FLOOR_RST;
         cfg_ff.throttle_ceiling   <= qafm_pkg::THR_CEILING_RST;
         cfg_ff.low_throttle_limit <= qafm_pkg::LOW_THR_LIMIT_RST;
         cfg_ff.arm_hold_ms        <= qafm_pkg::ARM_HOLD_MS_RST;
         cfg_ff.link_timeout_ms    <= qafm_pkg::LINK_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/qafm_mixer.sv]
// X-frame mixer: clamps the throttle base, mixes pitch, roll and yaw into
// four saturated motor commands. Depends on qafm_pkg.
module qafm_mixer (
   input  qafm_pkg::cfg_type    cfg,
   input  logic [15:0]          throttle,
   input  logic signed [15:0]   pitch,
   input  logic signed [15:0]   roll,
   input  logic signed [15:0]   yaw,
   output qafm_pkg::mix_type    mix
);

   localparam int EXT_W = qafm_pkg::MIX_W - 16;
   localparam int PAD_W = qafm_pkg::MIX_W - qafm_pkg::PW_W;

   qafm_pkg::pw_type      base;
   qafm_pkg::mix_sum_type base_s;
   qafm_pkg::mix_sum_type pitch_s;
   qafm_pkg::mix_sum_type roll_s;
   qafm_pkg::mix_sum_type yaw_s;
   qafm_pkg::mix_sum_type sum_fl;
   qafm_pkg::mix_sum_type sum_fr;
   qafm_pkg::mix_sum_type sum_rr;
   qafm_pkg::mix_sum_type sum_rl;

   always_comb begin
      base    = qafm_pkg::clamp_pw(qafm_pkg::mix_sum_type'({{EXT_W{1'b0}}, throttle}),
                                   cfg.throttle_floor, cfg.throttle_ceiling);
      base_s  = qafm_pkg::mix_sum_type'({{PAD_W{1'b0}}, base});
      pitch_s = qafm_pkg::mix_sum_type'({{EXT_W{pitch[15]}}, pitch});
      roll_s  = qafm_pkg::mix_sum_type'({{EXT_W{roll[15]}}, roll});
      yaw_s   = qafm_pkg::mix_sum_type'({{EXT_W{yaw[15]}}, yaw});

      sum_fl  = base_s + pitch_s - roll_s + yaw_s;
      sum_fr  = base_s + pitch_s + roll_s - yaw_s;
      sum_rr  = base_s - pitch_s + roll_s + yaw_s;
      sum_rl  = base_s - pitch_s - roll_s - yaw_s;

      mix.motor[0] = qafm_pkg::clamp_pw(sum_fl, cfg.throttle_floor, cfg.throttle_ceiling);
      mix.motor[1] = qafm_pkg::clamp_pw(sum_fr, cfg.throttle_floor, cfg.throttle_ceiling);
      mix.motor[2] = qafm_pkg::clamp_pw(sum_rr, cfg.throttle_floor, cfg.throttle_ceiling);
      mix.motor[3] = qafm_pkg::clamp_pw(sum_rl, cfg.throttle_floor, cfg.throttle_ceiling);
      mix.idle     = qafm_pkg::clamp_pw(qafm_pkg::mix_sum_type'({{PAD_W{1'b0}},
                                        cfg.throttle_floor}),
                                        cfg.throttle_floor, cfg.throttle_ceiling);
      mix.base_low = (base < cfg.low_throttle_limit);
   end

endmodule

[design/qafm_checker.sv]
// Port-level checks for the mixer block, bound onto the top level.
// Watches only the result channel; no package dependencies.
module qafm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [11:0]                      rsp_motor_front_left,
   input logic [11:0]                      rsp_motor_front_right,
   input logic [11:0]                      rsp_motor_rear_right,
   input logic [11:0]                      rsp_motor_rear_left,
   input logic                             rsp_armed_out,
   input logic                             rsp_packet_accepted,
   input logic                             rsp_failsafe_trip
);

   // a stalled result word holds valid, the front-left and rear-left motors, armed and both flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_motor_front_left) &&
      $stable(rsp_motor_rear_left) && $stable(rsp_armed_out) &&
      $stable(rsp_packet_accepted) && $stable(rsp_failsafe_trip))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_trip_not_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_packet_accepted && rsp_failsafe_trip))
      else $error("word flagged as both packet and failsafe tick");

   a_trip_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failsafe_trip |-> !rsp_armed_out)
      else $error("failsafe trip left the block armed");

   // disarmed motors all sit at one idle value
   a_disarmed_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_armed_out |->
      rsp_motor_front_left == rsp_motor_front_right &&
      rsp_motor_front_right == rsp_motor_rear_right &&
      rsp_motor_rear_right == rsp_motor_rear_left)
      else $error("motors differ while disarmed");

endmodule

bind quad_arming_failsafe_mixer_unit qafm_checker u_qafm_checker (.*);
